// ===== design/prqb_pkg.sv =====
// Shared types, constants and codes for the pendant report to quadrature bridge.
`timescale 1ns / 1ps
`default_nettype none

package prqb_pkg;

  // Speed levels cycled by the speed button
  localparam int SPEED_LEVELS = 4;
  localparam int SpeedW       = (SPEED_LEVELS > 1) ? $clog2(SPEED_LEVELS) : 1;

  // Axis select codes: X is the base, Y and Z follow it
  localparam logic [7:0] AXIS_X_CODE = 8'h11;
  localparam logic [7:0] AXIS_Z_CODE = 8'h13;

  // Saturation bounds of the pending step count
  localparam logic signed [16:0] PEND_MAX = 17'sd32767;
  localparam logic signed [16:0] PEND_MIN = -17'sd32767;

  // Quadrature phase numbering: idle, then phases one to four
  localparam logic [2:0] QPH_IDLE  = 3'd0;
  localparam logic [2:0] QPH_FIRST = 3'd1;
  localparam logic [2:0] QPH_SECOND = 3'd2;
  localparam logic [2:0] QPH_THIRD = 3'd3;
  localparam logic [2:0] QPH_LAST  = 3'd4;

  // Register reset values
  localparam logic [7:0] HALF_PULSE_RST   = 8'd2;
  localparam logic [9:0] AXIS_PULSE_RST   = 10'd100;
  localparam logic [7:0] SPEED_BUTTON_RST = 8'h0D;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 10;
  localparam int InDataW  = 24;
  localparam int OutDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HALF_PULSE   = 2'd0,
    CFG_AXIS_PULSE   = 2'd1,
    CFG_SPEED_BUTTON = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_REPORT = 1'b0,
    OP_TICK   = 1'b1
  } opcode_e;

  typedef struct packed {
    logic [7:0] half_pulse_ticks;
    logic [9:0] axis_pulse_ticks;
    logic [7:0] speed_button_code;
  } cfg_t;

  typedef struct packed {
    opcode_e           opcode;
    logic [7:0]        button_code;
    logic [7:0]        axis_code;
    logic signed [7:0] wheel_delta;
  } item_t;

  typedef struct packed {
    logic               quad_a;
    logic               quad_b;
    logic [2:0]         axis_lines_n;
    logic [3:0]         speed_lines_n;
    logic signed [15:0] steps_pending;
  } result_t;

endpackage

`default_nettype wire

// ===== design/prqb_cfg_regs.sv =====
// Configuration registers of the bridge, written through a plain write port.
`timescale 1ns / 1ps
`default_nettype none

module prqb_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [prqb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [prqb_pkg::CfgDataW-1:0] cfg_data_i,
  output prqb_pkg::cfg_t                     cfg_o
);
  import prqb_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode the write; unknown indexes leave everything as it is
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_HALF_PULSE:   cfg_d.half_pulse_ticks  = cfg_data_i[7:0];
        CFG_AXIS_PULSE:   cfg_d.axis_pulse_ticks  = cfg_data_i[9:0];
        CFG_SPEED_BUTTON: cfg_d.speed_button_code = cfg_data_i[7:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_pulse_ticks  <= HALF_PULSE_RST;
      cfg_q.axis_pulse_ticks  <= AXIS_PULSE_RST;
      cfg_q.speed_button_code <= SPEED_BUTTON_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== design/prqb_engine.sv =====
// Bridge state and the single-pass update for one report or tick item.
`timescale 1ns / 1ps
`default_nettype none

module prqb_engine (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            advance_i,
  input  wire prqb_pkg::item_t item_i,
  input  wire prqb_pkg::cfg_t  cfg_i,
  output prqb_pkg::result_t    result_o
);
  import prqb_pkg::*;

  logic signed [15:0] pend_q, pend_d;
  logic [7:0]         prev_axis_q, prev_axis_d;
  logic [7:0]         prev_button_q, prev_button_d;
  logic [SpeedW-1:0]  speed_q, speed_d;
  logic [2:0]         phase_q, phase_d;
  logic               dir_q, dir_d;
  logic [7:0]         phase_tmr_q, phase_tmr_d;
  logic [9:0]         axis_tmr_q, axis_tmr_d;
  logic [1:0]         pulsed_q, pulsed_d;

  logic [7:0]         half_len;
  logic [9:0]         axis_len;
  logic signed [15:0] pend_base;
  logic signed [16:0] pend_sum;
  logic [7:0]         tmr_dec;

  // Zero in a timing register acts as one
  assign half_len = (cfg_i.half_pulse_ticks == '0) ? 8'd1 : cfg_i.half_pulse_ticks;
  assign axis_len = (cfg_i.axis_pulse_ticks == '0) ? 10'd1 : cfg_i.axis_pulse_ticks;

  // Next state for the item at the head of the input register
  always_comb begin
    pend_d        = pend_q;
    prev_axis_d   = prev_axis_q;
    prev_button_d = prev_button_q;
    speed_d       = speed_q;
    phase_d       = phase_q;
    dir_d         = dir_q;
    phase_tmr_d   = phase_tmr_q;
    axis_tmr_d    = axis_tmr_q;
    pulsed_d      = pulsed_q;
    pend_base     = pend_q;
    pend_sum      = '0;
    tmr_dec       = phase_tmr_q;

    if (item_i.opcode == OP_REPORT) begin
      // Axis change: drop pending steps, restart the axis pulse for X, Y or Z, else end it
      if (item_i.axis_code != prev_axis_q) begin
        prev_axis_d = item_i.axis_code;
        axis_tmr_d  = '0;
        pend_base   = '0;
        if (item_i.axis_code >= AXIS_X_CODE && item_i.axis_code <= AXIS_Z_CODE) begin
          pulsed_d   = 2'(item_i.axis_code - AXIS_X_CODE);
          axis_tmr_d = axis_len;
        end
      end
      // Add the wheel delta and saturate
      pend_sum = 17'(pend_base) + 17'(item_i.wheel_delta);
      if (pend_sum > PEND_MAX) begin
        pend_d = 16'(PEND_MAX);
      end else if (pend_sum < PEND_MIN) begin
        pend_d = 16'(PEND_MIN);
      end else begin
        pend_d = pend_sum[15:0];
      end
      // Speed button release cycles the speed
      if (item_i.button_code == '0 && prev_button_q != '0 &&
          prev_button_q == cfg_i.speed_button_code) begin
        if (speed_q == SpeedW'(SPEED_LEVELS - 1)) begin
          speed_d = '0;
        end else begin
          speed_d = speed_q + 1'b1;
        end
      end
      prev_button_d = item_i.button_code;
    end else begin
      // Count down the axis pulse
      if (axis_tmr_q != '0) begin
        axis_tmr_d = axis_tmr_q - 1'b1;
      end
      // Advance the running pattern
      if (phase_q != QPH_IDLE) begin
        if (phase_tmr_q != '0) begin
          tmr_dec = phase_tmr_q - 1'b1;
        end
        phase_tmr_d = tmr_dec;
        if (tmr_dec == '0) begin
          if (phase_q == QPH_LAST) begin
            phase_d = QPH_IDLE;
          end else begin
            phase_d     = phase_q + 1'b1;
            phase_tmr_d = half_len;
          end
        end
      end
      // Start the next step when the generator is free
      if (phase_d == QPH_IDLE && pend_q != '0) begin
        if (pend_q > 16'sd0) begin
          dir_d  = 1'b0;
          pend_d = pend_q - 16'sd1;
        end else begin
          dir_d  = 1'b1;
          pend_d = pend_q + 16'sd1;
        end
        phase_d     = QPH_FIRST;
        phase_tmr_d = half_len;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q        <= '0;
      prev_axis_q   <= '0;
      prev_button_q <= '0;
      speed_q       <= '0;
      phase_q       <= QPH_IDLE;
      dir_q         <= 1'b0;
      phase_tmr_q   <= '0;
      axis_tmr_q    <= '0;
      pulsed_q      <= '0;
    end else if (advance_i) begin
      pend_q        <= pend_d;
      prev_axis_q   <= prev_axis_d;
      prev_button_q <= prev_button_d;
      speed_q       <= speed_d;
      phase_q       <= phase_d;
      dir_q         <= dir_d;
      phase_tmr_q   <= phase_tmr_d;
      axis_tmr_q    <= axis_tmr_d;
      pulsed_q      <= pulsed_d;
    end
  end

  // Map the updated state onto the output lines
  always_comb begin
    result_o.quad_a        = 1'b0;
    result_o.quad_b        = 1'b0;
    result_o.axis_lines_n  = 3'b111;
    result_o.speed_lines_n = 4'hF;
    result_o.steps_pending = pend_d;
    case (phase_d)
      QPH_FIRST: begin
        result_o.quad_a = ~dir_d;
        result_o.quad_b = dir_d;
      end
      QPH_SECOND: begin
        result_o.quad_a = 1'b1;
        result_o.quad_b = 1'b1;
      end
      QPH_THIRD: begin
        result_o.quad_a = dir_d;
        result_o.quad_b = ~dir_d;
      end
      default: begin
        result_o.quad_a = 1'b0;
        result_o.quad_b = 1'b0;
      end
    endcase
    if (axis_tmr_d != '0 && pulsed_d < 2'd3) begin
      result_o.axis_lines_n[pulsed_d] = 1'b0;
    end
    if (int'(speed_d) < 4) begin
      result_o.speed_lines_n[2'(speed_d)] = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== design/pendant_report_to_quadrature_bridge_core.sv =====
// Top level of the pendant report to quadrature bridge: handshakes and pipeline registers.
//
//  channel   | direction | tdata (low bit up)                                  | tuser
//  s_axis    | in        | button_code[7:0], axis_code[7:0], wheel_delta[7:0]  | opcode
//  m_axis    | out       | quad_a, quad_b, axis_lines_n[2:0],                  | -
//            |           | speed_lines_n[3:0], steps_pending[15:0], 7'b0       |
//  cfg       | in        | cfg_we_i, cfg_index_i, cfg_data_i                   | -
//
// One item per cycle sustained while the result side does not stall.
// The state update for an item is one combinational pass in the engine, taken as the
// item moves from the input register into the result register.
// Reset clears all state to speed one, no pulse, nothing pending, generator idle.
// A stalled result register holds the item in the input register; both stall together.
`timescale 1ns / 1ps
`default_nettype none

module pendant_report_to_quadrature_bridge_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // button_code[7:0], axis_code[15:8], wheel_delta[23:16]
  input  wire logic [prqb_pkg::InDataW-1:0]  s_axis_tdata_i,
  // opcode
  input  wire logic                          s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // quad_a[0], quad_b[1], axis_lines_n[4:2], speed_lines_n[8:5], steps_pending[24:9]
  output logic [prqb_pkg::OutDataW-1:0]      m_axis_tdata_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [prqb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [prqb_pkg::CfgDataW-1:0] cfg_data_i
);
  import prqb_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    in_valid_q;
  result_t res_d, res_q;
  logic    out_valid_q;
  logic    advance;
  logic    in_take;

  prqb_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Move the held item on when the result register is free
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.opcode      <= opcode_e'(s_axis_tuser_i);
      item_q.button_code <= s_axis_tdata_i[7:0];
      item_q.axis_code   <= s_axis_tdata_i[15:8];
      item_q.wheel_delta <= s_axis_tdata_i[23:16];
    end
  end

  prqb_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item_q),
    .cfg_i     (cfg),
    .result_o  (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, res_q.steps_pending, res_q.speed_lines_n,
                            res_q.axis_lines_n, res_q.quad_b, res_q.quad_a};

  // At most one axis line is pulled low
  a_axis_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> $onehot0(~res_q.axis_lines_n))
    else $error("more than one axis line active");

  // Exactly one speed line is active
  a_speed_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> $onehot(~res_q.speed_lines_n))
    else $error("speed lines not one-hot");

  // Pending count never reaches the unsaturated minimum
  a_pend_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (res_q.steps_pending != 16'sh8000))
    else $error("pending count out of range");

  // A held item is not lost while the result side stalls
  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(item_q)))
    else $error("held item dropped");

endmodule

`default_nettype wire
